// File: src/txcon_pkg.sv
package txcon_pkg;

	// Default screen geometry and tab spacing.
	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 8;

	// Attribute byte after reset: light gray on black.
	localparam logic [7:0] ATTR_RESET = 8'h07;

	// Item modes.
	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// Character codes with special meaning.
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_pos;
		logic [15:0] read_data;
		logic        scrolled;
	} out_item_t;

endpackage

// File: src/text_console_writer.sv
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (attribute in the high byte,
// character in the low byte) held in one synchronous single-write, single-read memory, plus a
// cursor. Each input transaction (put character, clear screen, read cell) returns exactly one
// result transaction carrying the cursor after the item. A put character that does not scroll,
// a read cell and the unused mode go straight to the publish step after acceptance; a new item
// is taken only once the previous one has published its result. A clear fills the screen
// through the one memory write port, a cell per cycle, before it publishes. A put character
// that scrolls first copies each row one line up: the copy streams through the memory one cell
// per cycle (read one row ahead, written in the cycle after the read), the copy then drains, and
// the bottom row is then blanked one cell per cycle before the result is published. No input is
// accepted while a clear or a scroll is in progress. A result that waits on
// the receiver sits in the output register while the next item is processed; that item then
// holds in its publish step and the input stalls. Screen cells are undefined until the first
// clear. The attribute register is written through the configuration port, which is always
// ready.
module text_console_writer #(
	parameter int COLUMNS  = txcon_pkg::COLUMNS_DEF,
	parameter int ROWS     = txcon_pkg::ROWS_DEF,
	parameter int TAB_STOP = txcon_pkg::TAB_STOP_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  txcon_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output txcon_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_data
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int PW         = $clog2(CELL_COUNT);
	localparam int CW         = $clog2(COLUMNS);
	localparam int RW         = $clog2(ROWS);
	localparam int TW         = $clog2(TAB_STOP);
	// Wide enough for a column that has run past the right edge by up to one tab.
	localparam int COL_W      = $clog2(COLUMNS + TAB_STOP);
	// Wide enough for both the 11-bit read index and the cell count itself.
	localparam int IW         = (PW + 1 > 12) ? PW + 1 : 12;

	localparam logic [PW-1:0] LAST_CELL = PW'(CELL_COUNT - 1);
	localparam logic [PW-1:0] LAST_BASE = PW'((ROWS - 1) * COLUMNS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_COPY,
		S_FILL,
		S_PUB
	} state_t;

	state_t state_q;

	// Cursor: column, row, row*COLUMNS and column modulo TAB_STOP, all kept incrementally.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] row_base_q;
	logic [TW-1:0] phase_q;

	logic [7:0]    attr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] wr_ptr_q;
	logic          rd_more_q;
	logic          copy_s1;
	logic          scrolled_q;
	logic          is_read_q;
	logic          out_valid_q;
	txcon_pkg::out_item_t out_q;

	// Screen memory and its registered read data.
	logic [15:0]   mem [CELL_COUNT];
	logic [15:0]   rd_data_q;
	logic          we;
	logic          re;
	logic [PW-1:0] waddr;
	logic [PW-1:0] raddr;
	logic [15:0]   wdata;

	logic             in_acc;
	logic             in_range;
	logic [COL_W-1:0] col_t;
	logic [TW-1:0]    phase_t;
	logic             line_adv;
	logic             put_wr;
	logic             need_scroll;
	logic [15:0]      blank;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign blank     = {attr_q, txcon_pkg::CH_SPACE};
	assign in_range  = IW'(in_data.cell_index) < IW'(CELL_COUNT);

	// Cursor movement for a put character. A column that reaches the right edge wraps to
	// the next line; a line advance from the bottom row needs a scroll.
	always_comb begin
		col_t    = COL_W'(col_q);
		phase_t  = phase_q;
		line_adv = 1'b0;
		put_wr   = 1'b0;
		case (in_data.char_code)
			txcon_pkg::CH_BS: begin
				if (col_q != '0) begin
					col_t   = col_t - 1'b1;
					phase_t = (phase_q == '0) ? TW'(TAB_STOP - 1) : phase_q - 1'b1;
				end
			end
			txcon_pkg::CH_TAB: begin
				col_t   = col_t + COL_W'(TAB_STOP) - COL_W'(phase_q);
				phase_t = '0;
			end
			txcon_pkg::CH_CR: begin
				col_t   = '0;
				phase_t = '0;
			end
			txcon_pkg::CH_LF: begin
				col_t    = '0;
				phase_t  = '0;
				line_adv = 1'b1;
			end
			default: begin
				// Codes 8'h20 to 8'h7F only; other control codes and high codes change nothing.
				if (!in_data.char_code[7] && in_data.char_code >= txcon_pkg::CH_SPACE) begin
					put_wr  = 1'b1;
					col_t   = col_t + 1'b1;
					phase_t = (phase_q == TW'(TAB_STOP - 1)) ? '0 : phase_q + 1'b1;
				end
			end
		endcase
		if (col_t >= COL_W'(COLUMNS)) begin
			col_t    = '0;
			phase_t  = '0;
			line_adv = 1'b1;
		end
		need_scroll = line_adv && (row_q == RW'(ROWS - 1));
	end

	// Memory port control. During the scroll copy the read runs one row ahead of the write,
	// so the two never touch the same cell in one cycle; no forwarding is needed.
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = wr_ptr_q;
		raddr = rd_ptr_q;
		wdata = blank;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && in_data.mode == txcon_pkg::MODE_PUT && put_wr) begin
					we    = 1'b1;
					waddr = row_base_q + PW'(col_q);
					wdata = {attr_q, in_data.char_code};
				end
				if (in_acc && in_data.mode == txcon_pkg::MODE_READ && in_range) begin
					re    = 1'b1;
					raddr = PW'(in_data.cell_index);
				end
			end
			S_COPY: begin
				re    = rd_more_q;
				we    = copy_s1;
				wdata = rd_data_q;
			end
			S_FILL: begin
				we = 1'b1;
			end
			S_PUB: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= txcon_pkg::ATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			row_base_q  <= '0;
			phase_q     <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			rd_more_q   <= 1'b0;
			copy_s1     <= 1'b0;
			scrolled_q  <= 1'b0;
			is_read_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// In the publish step the result register is refilled instead of emptied.
			if (out_valid_q && out_ready && state_q != S_PUB) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						scrolled_q <= 1'b0;
						is_read_q  <= 1'b0;
						state_q    <= S_PUB;
						unique case (in_data.mode)
							txcon_pkg::MODE_PUT: begin
								col_q   <= CW'(col_t);
								phase_q <= phase_t;
								if (need_scroll) begin
									// Row and row base stay on the bottom line.
									scrolled_q <= 1'b1;
									rd_ptr_q   <= PW'(COLUMNS);
									rd_more_q  <= 1'b1;
									copy_s1    <= 1'b0;
									wr_ptr_q   <= '0;
									state_q    <= S_COPY;
								end else if (line_adv) begin
									row_q      <= row_q + 1'b1;
									row_base_q <= row_base_q + PW'(COLUMNS);
								end
							end
							txcon_pkg::MODE_CLEAR: begin
								col_q      <= '0;
								row_q      <= '0;
								row_base_q <= '0;
								phase_q    <= '0;
								wr_ptr_q   <= '0;
								state_q    <= S_FILL;
							end
							txcon_pkg::MODE_READ: begin
								is_read_q <= in_range;
							end
							default: begin
							end
						endcase
					end
				end
				S_COPY: begin
					if (rd_more_q) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
						if (rd_ptr_q == LAST_CELL) begin
							rd_more_q <= 1'b0;
						end
					end
					copy_s1 <= rd_more_q;
					if (copy_s1) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
					end
					// The write pointer now sits at the start of the bottom row.
					if (!rd_more_q && !copy_s1) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (wr_ptr_q == LAST_CELL) begin
						state_q <= S_PUB;
					end else begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
					end
				end
				S_PUB: begin
					if (!out_valid_q || out_ready) begin
						out_q.cursor_col <= 7'(col_q);
						out_q.cursor_row <= 5'(row_q);
						out_q.cursor_pos <= 11'(row_base_q + PW'(col_q));
						out_q.read_data  <= is_read_q ? rd_data_q : 16'h0000;
						out_q.scrolled   <= scrolled_q;
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The cursor never rests outside the screen, and the row base tracks the row.
	assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= RW'(ROWS - 1) && col_q <= CW'(COLUMNS - 1) && row_base_q <= LAST_BASE)
		else $error("cursor left the screen");

	// Reads and writes of the screen memory never hit the same cell in one cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (waddr != raddr))
		else $error("memory read and write collide");

	// A finished item whose result register is free is offered in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUB && (!out_valid_q || out_ready)) |=> (out_valid && state_q == S_IDLE))
		else $error("result not published");

endmodule
